// ===== src/assert_macros.svh =====
// Assertion macros used by the top level of the time counter.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sttc_pkg.sv =====
// Package for the steppable simulation time counter: payload structs, command
// codes, register indexes, reset constants and pipeline control structs.
package sttc_pkg;

  localparam int TIME_WIDTH_DEF = 64;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 64;
  localparam longint unsigned BASE_STEP_RESET = 64'd1000000;

  typedef enum logic [3:0] {
    CMD_STEP      = 4'd0,
    CMD_SET_STEP  = 4'd1,
    CMD_SET_TIME  = 4'd2,
    CMD_SET_EXT   = 4'd3,
    CMD_PAUSE     = 4'd4,
    CMD_CONT_FOR  = 4'd5,
    CMD_CONT_UNTIL = 4'd6,
    CMD_SINGLE    = 4'd7,
    CMD_N_STEPS   = 4'd8,
    CMD_QUERY     = 4'd9
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_STEP  = 1'b0,
    CFG_START_TIME = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [63:0] operand_value;
    logic               flag;
  } req_t;

  typedef struct packed {
    logic signed [63:0] now_time;
    logic signed [63:0] pause_time;
    logic               paused;
    logic               external_mode;
    logic               advanced;
  } res_t;

  // Load enables for the two front stages.
  typedef struct packed {
    logic load1;
    logic load2;
  } prep_ctl_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } prep_status_t;

  // Core control: take updates the state, move loads the result register.
  typedef struct packed {
    logic take;
    logic move;
  } core_ctl_t;

endpackage

// ===== src/sttc_prep.sv =====
// Front stages of the time counter: operand trim and a split multiply of the
// clamped count by the base step. Depends on sttc_pkg.
module sttc_prep #(
  parameter int TIME_WIDTH = sttc_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  sttc_pkg::req_t                req,
  input  logic [TIME_WIDTH-1:0]         base,
  input  sttc_pkg::prep_ctl_t           ctl,
  output sttc_pkg::prep_status_t        status,
  output logic [3:0]                    s2_cmd,
  output logic [TIME_WIDTH-1:0]         s2_value,
  output logic                          s2_flag,
  output logic [TIME_WIDTH-1:0]         s2_prod
);

  localparam int LO = TIME_WIDTH / 2;
  localparam int HI = TIME_WIDTH - LO;

  logic                  s1_valid;
  logic                  s2_valid;
  logic [3:0]            s1_cmd;
  logic [TIME_WIDTH-1:0] s1_value;
  logic                  s1_flag;
  logic [2*LO-1:0]       pp_ll;
  logic [HI-1:0]         pp_lh;
  logic [HI-1:0]         pp_hl;

  logic [TIME_WIDTH-1:0] value_in;
  logic [TIME_WIDTH-1:0] count;
  logic [2*LO-1:0]       prod_ll;
  logic [HI-1:0]         cross_sum;

  // A negative count means zero steps.
  assign value_in = req.operand_value[TIME_WIDTH-1:0];
  assign count    = value_in[TIME_WIDTH-1] ? '0 : value_in;
  assign prod_ll  = {{LO{1'b0}}, count[LO-1:0]} * {{LO{1'b0}}, base[LO-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ctl.load1) begin
      s1_valid <= req_valid;
    end
    if (ctl.load1) begin
      s1_cmd   <= req.cmd;
      s1_value <= value_in;
      s1_flag  <= req.flag;
      pp_ll    <= prod_ll;
      pp_lh    <= HI'(count[LO-1:0] * base[TIME_WIDTH-1:LO]);
      pp_hl    <= HI'(count[TIME_WIDTH-1:LO] * base[LO-1:0]);
    end
  end

  // Only the low TIME_WIDTH bits of the product are kept.
  assign cross_sum = pp_lh + pp_hl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ctl.load2) begin
      s2_valid <= s1_valid;
    end
    if (ctl.load2) begin
      s2_cmd   <= s1_cmd;
      s2_value <= s1_value;
      s2_flag  <= s1_flag;
      s2_prod  <= TIME_WIDTH'(pp_ll) + {cross_sum, {LO{1'b0}}};
    end
  end

  assign status.s1_valid = s1_valid;
  assign status.s2_valid = s2_valid;

endmodule

// ===== src/sttc_core.sv =====
// State and result stage of the time counter: executes one command per cycle
// while ctl.take is high, on the time, step, target and mode registers. Depends on sttc_pkg.
module sttc_core #(
  parameter int TIME_WIDTH = sttc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sttc_pkg::core_ctl_t                 ctl,
  input  logic [3:0]                          cmd,
  input  logic [TIME_WIDTH-1:0]               value,
  input  logic                                flag,
  input  logic [TIME_WIDTH-1:0]               prod,
  input  logic                                cfg_write,
  input  logic [sttc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sttc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [TIME_WIDTH-1:0]               base,
  output logic                                res_valid,
  output sttc_pkg::res_t                      res
);

  localparam logic signed [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [TIME_WIDTH-1:0] ONE = TIME_WIDTH'(1);
  localparam logic signed [TIME_WIDTH-1:0] BASE_RST = TIME_WIDTH'(sttc_pkg::BASE_STEP_RESET);

  logic signed [TIME_WIDTH-1:0] current_time;
  logic signed [TIME_WIDTH-1:0] pending_step;
  logic signed [TIME_WIDTH-1:0] pause_target;
  logic signed [TIME_WIDTH-1:0] step_base;
  logic                         ext_only;

  logic signed [TIME_WIDTH-1:0] current_time_next;
  logic signed [TIME_WIDTH-1:0] pending_step_next;
  logic signed [TIME_WIDTH-1:0] pause_target_next;
  logic                         ext_only_next;
  logic                         advanced_next;

  logic signed [TIME_WIDTH-1:0] v;
  logic signed [TIME_WIDTH-1:0] v_pos;
  logic signed [TIME_WIDTH-1:0] gap;
  logic signed [TIME_WIDTH-1:0] single_step;
  logic [63:0]                  base_raw;
  logic signed [TIME_WIDTH-1:0] base_cut;

  assign v     = value;
  assign v_pos = v[TIME_WIDTH-1] ? '0 : v;
  assign gap   = v - current_time;
  assign single_step = (ext_only && pending_step == '0) ? step_base : pending_step;

  // Base step: top bit dropped, cut to the time width, at least one.
  assign base_raw = {1'b0, cfg_data[62:0]};
  assign base_cut = base_raw[TIME_WIDTH-1:0];

  always_comb begin
    current_time_next = current_time;
    pending_step_next = pending_step;
    pause_target_next = pause_target;
    ext_only_next     = ext_only;
    advanced_next     = 1'b0;
    case (sttc_pkg::cmd_t'(cmd))
      sttc_pkg::CMD_STEP: begin
        if (current_time < pause_target) begin
          current_time_next = current_time + pending_step;
          pending_step_next = ext_only ? '0 : step_base;
          advanced_next     = 1'b1;
        end
      end
      sttc_pkg::CMD_SET_STEP: begin
        pending_step_next = (v < ONE) ? ONE : v;
      end
      sttc_pkg::CMD_SET_TIME: begin
        pending_step_next = (gap < ONE) ? ONE : gap;
      end
      sttc_pkg::CMD_SET_EXT: begin
        ext_only_next     = flag;
        pending_step_next = flag ? '0 : step_base;
      end
      sttc_pkg::CMD_PAUSE: begin
        pause_target_next = flag ? current_time : TIME_MAX;
      end
      sttc_pkg::CMD_CONT_FOR: begin
        pause_target_next = current_time + v_pos;
      end
      sttc_pkg::CMD_CONT_UNTIL: begin
        pause_target_next = (v < current_time) ? current_time : v;
      end
      sttc_pkg::CMD_SINGLE: begin
        pause_target_next = current_time + single_step;
      end
      sttc_pkg::CMD_N_STEPS: begin
        pause_target_next = current_time + $signed(prod);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      pending_step <= BASE_RST;
      pause_target <= TIME_MAX;
      step_base    <= BASE_RST;
      ext_only     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == sttc_pkg::CFG_BASE_STEP) begin
          step_base    <= (base_cut < ONE) ? ONE : base_cut;
          pending_step <= (base_cut < ONE) ? ONE : base_cut;
        end else begin
          current_time <= cfg_data[TIME_WIDTH-1:0];
        end
      end else if (ctl.take) begin
        current_time <= current_time_next;
        pending_step <= pending_step_next;
        pause_target <= pause_target_next;
        ext_only     <= ext_only_next;
      end
      if (ctl.move) begin
        res_valid <= ctl.take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res.now_time      <= 64'(current_time_next);
      res.pause_time    <= 64'(pause_target_next);
      res.paused        <= !(current_time_next < pause_target_next);
      res.external_mode <= ext_only_next;
      res.advanced      <= advanced_next;
    end
  end

  assign base = step_base;

endmodule

// ===== src/steppable_sim_time_counter.sv =====
// Top level of the steppable simulation time counter.
// Depends on sttc_pkg, sttc_prep, sttc_core and assert_macros.svh.
//
// - Request channel (req_valid, req_stall, req): one command per request.
//   A request is taken at a rising edge with req_valid high and req_stall low.
// - Result channel (res_valid, res_stall, res): exactly one result per request,
//   in request order, taken at an edge with res_valid high and res_stall low.
// - Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
//   the base step (index 0) or loads the current time (index 1). cfg_ready is
//   always high; write only while no request is in flight.
// - Pipeline: three register stages. The first stage forms the partial products
//   of step count times base step, the second sums them, and the third updates
//   the state and registers the result.
// - Throughput: one request per cycle while res_stall is low, sustained, even for
//   dependent commands, since all state lives in the last stage.
// - Reset (rst, synchronous): time zero, pending and base step 1000000 ns, pause
//   target the largest positive time, external mode off, all stages empty.
// - Stall: under res_stall the empty front stages still fill; req_stall rises
//   only when all three stages hold a request.
`include "assert_macros.svh"

module steppable_sim_time_counter #(
  parameter int TIME_WIDTH = sttc_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  sttc_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output sttc_pkg::res_t                    res,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sttc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sttc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sttc_pkg::prep_ctl_t    prep_ctl;
  sttc_pkg::prep_status_t prep_status;
  sttc_pkg::core_ctl_t    core_ctl;

  logic [3:0]            s2_cmd;
  logic [TIME_WIDTH-1:0] s2_value;
  logic                  s2_flag;
  logic [TIME_WIDTH-1:0] s2_prod;
  logic [TIME_WIDTH-1:0] base;
  logic                  move;
  logic                  pipe_empty;

  // The result register moves when it is empty or being taken; each earlier
  // stage moves when it is empty or the stage after it moves.
  assign move           = !res_valid || !res_stall;
  assign prep_ctl.load2 = !prep_status.s2_valid || move;
  assign prep_ctl.load1 = !prep_status.s1_valid || prep_ctl.load2;
  assign req_stall      = !prep_ctl.load1;

  assign core_ctl.move = move;
  assign core_ctl.take = move && prep_status.s2_valid;

  assign cfg_ready = 1'b1;

  assign pipe_empty = !res_valid && !prep_status.s1_valid && !prep_status.s2_valid;

  sttc_prep #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .base     (base),
    .ctl      (prep_ctl),
    .status   (prep_status),
    .s2_cmd   (s2_cmd),
    .s2_value (s2_value),
    .s2_flag  (s2_flag),
    .s2_prod  (s2_prod)
  );

  sttc_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (core_ctl),
    .cmd      (s2_cmd),
    .value    (s2_value),
    .flag     (s2_flag),
    .prod     (s2_prod),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .base     (base),
    .res_valid(res_valid),
    .res      (res)
  );

  // The request side can only stall when a result is waiting downstream.
  `ASSERT_CLK(a_stall_needs_result, req_stall |-> res_valid, "request stalled, no result held")

  // A request in the second stage that moves on must show up as a result.
  `ASSERT_CLK(a_take_gives_result, core_ctl.take |=> res_valid, "request produced no result")

  // Every stage is empty at the first edge after reset is released.
  `ASSERT_ALWAYS(a_empty_after_reset, (!rst && $past(rst)) |-> pipe_empty, "pipeline not empty")

endmodule
